// File: rtl/prht_pkg.sv
// Shared types, codes and constants for the pair rank hash table.
`default_nettype none

package prht_pkg;

   localparam int ID_FIELD_BITS = 16;
   localparam int RANK_BITS = 16;
   localparam int STATUS_BITS = 3;
   localparam int OP_BITS = 2;
   localparam int SIZE_BITS = 5;

   localparam int DEF_TABLE_SLOTS = 131072;
   localparam int DEF_ID_BITS = 16;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd17;
   localparam logic [SIZE_BITS-1:0] SIZE_MIN = 5'd4;

   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam int MIX_SHIFT_A = 30;
   localparam int MIX_SHIFT_B = 27;
   localparam int MIX_SHIFT_C = 31;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2
   } prht_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_HIT      = 3'd0,
      STAT_MISS     = 3'd1,
      STAT_INSERTED = 3'd2,
      STAT_DUP      = 3'd3,
      STAT_FULL     = 3'd4,
      STAT_CLEARED  = 3'd5
   } prht_status_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_END
   } prht_mul_type;

   typedef enum logic [3:0] {
      ST_WIPE_INIT,
      ST_IDLE,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_MUL_END,
      ST_READ,
      ST_CHECK,
      ST_WIPE,
      ST_UNUSED_OP
   } prht_state_type;

   typedef struct packed {
      logic            load_req;
      prht_mul_type    mul_step;
      logic            mul_pass;
      logic            mem_read;
      logic            probe_advance;
      logic            entry_write;
      logic            wipe_write;
      logic            rsp_load;
      prht_status_type rsp_status;
   } prht_cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               rd_valid;
      logic               rd_match;
      logic               probe_last;
      logic               wipe_last;
   } prht_stat_type;

endpackage

`default_nettype wire

// File: rtl/prht_ctrl.sv
// Controller state machine: sequences hashing, probing, clearing and the response register.
`default_nettype none

module prht_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [prht_pkg::OP_BITS-1:0] req_op,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output prht_pkg::prht_cmd_type        cmd,
   input  wire prht_pkg::prht_stat_type  stat
);
   import prht_pkg::*;

   prht_state_type state_ff, state_in;
   logic           pass_ff, pass_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE_INIT;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      case (state_ff)
         ST_WIPE_INIT: begin
            if (stat.wipe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  OP_LOOKUP, OP_INSERT: begin
                     state_in = ST_MUL_LL;
                     pass_in  = 1'b0;
                  end
                  OP_CLEAR: state_in = ST_WIPE;
                  default:  state_in = ST_UNUSED_OP;
               endcase
            end
         end
         ST_MUL_LL: state_in = ST_MUL_LH;
         ST_MUL_LH: state_in = ST_MUL_HL;
         ST_MUL_HL: state_in = ST_MUL_END;
         ST_MUL_END: begin
            if (pass_ff) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_MUL_LL;
               pass_in  = 1'b1;
            end
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.rd_valid && !stat.rd_match && !stat.probe_last) begin
               state_in = ST_READ;
            end else if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WIPE: begin
            if (stat.wipe_last && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_UNUSED_OP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.mul_step   = MUL_NONE;
      cmd.mul_pass   = pass_ff;
      cmd.rsp_status = STAT_MISS;
      req_tready     = 1'b0;
      case (state_ff)
         ST_WIPE_INIT: cmd.wipe_write = 1'b1;
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_MUL_LL:  cmd.mul_step = MUL_LL;
         ST_MUL_LH:  cmd.mul_step = MUL_LH;
         ST_MUL_HL:  cmd.mul_step = MUL_HL;
         ST_MUL_END: cmd.mul_step = MUL_END;
         ST_READ:    cmd.mem_read = 1'b1;
         ST_CHECK: begin
            if (stat.rd_valid && !stat.rd_match && !stat.probe_last) begin
               cmd.probe_advance = 1'b1;
            end else if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (!stat.rd_valid) begin
                  if (stat.op == OP_INSERT) begin
                     cmd.rsp_status  = STAT_INSERTED;
                     cmd.entry_write = 1'b1;
                  end else begin
                     cmd.rsp_status = STAT_MISS;
                  end
               end else if (stat.rd_match) begin
                  cmd.rsp_status = (stat.op == OP_INSERT) ? STAT_DUP : STAT_HIT;
               end else begin
                  cmd.rsp_status = (stat.op == OP_INSERT) ? STAT_FULL : STAT_MISS;
               end
            end
         end
         ST_WIPE: begin
            if (!stat.wipe_last) begin
               cmd.wipe_write = 1'b1;
            end else if (rsp_free) begin
               cmd.wipe_write = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STAT_CLEARED;
            end
         end
         ST_UNUSED_OP: begin
            if (rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STAT_MISS;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/prht_dp.sv
// Datapath: request registers, shared 32x32 hash multiplier, slot memory and response register.
`default_nettype none

module prht_dp #(
   parameter int TABLE_SLOTS = prht_pkg::DEF_TABLE_SLOTS,
   parameter int ID_BITS = prht_pkg::DEF_ID_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   input  wire logic [prht_pkg::SIZE_BITS-1:0] csr_data,
   input  wire logic [prht_pkg::OP_BITS-1:0]   req_op,
   input  wire logic [47:0]                    req_tdata,
   input  wire prht_pkg::prht_cmd_type         cmd,
   output prht_pkg::prht_stat_type             stat,
   output logic [prht_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [prht_pkg::RANK_BITS-1:0]      rsp_rank
);
   import prht_pkg::*;

   localparam int SLOT_BITS = $clog2(TABLE_SLOTS + 1) - 1;
   localparam int DEPTH = 1 << SLOT_BITS;
   localparam int KEY_ID_BITS = (ID_BITS < ID_FIELD_BITS) ? ID_BITS : ID_FIELD_BITS;
   localparam int PAIR_BITS = 2 * KEY_ID_BITS;
   localparam int WORD_BITS = 1 + PAIR_BITS + RANK_BITS;

   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] size_eff;
   logic [SLOT_BITS-1:0] mask;

   logic [ID_FIELD_BITS-1:0] left_w;
   logic [ID_FIELD_BITS-1:0] right_w;
   logic [63:0]              key_w;
   logic [63:0]              pre_w;

   logic [OP_BITS-1:0]   op_ff;
   logic [PAIR_BITS-1:0] pair_ff;
   logic [RANK_BITS-1:0] rank_ff;

   logic [63:0] x_ff, x_in;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic [63:0] mul_const;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_prod;
   logic [63:0] sum_w;
   logic [63:0] hash_w;

   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [SLOT_BITS-1:0] probe_ff;
   logic [SLOT_BITS-1:0] wipe_addr_ff;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_ff;
   logic                 mem_we;
   logic [SLOT_BITS-1:0] mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [RANK_BITS-1:0]   rsp_rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   always_comb begin
      if (size_ff < SIZE_MIN) begin
         size_eff = SIZE_MIN;
      end else if (size_ff > SIZE_BITS'(SLOT_BITS)) begin
         size_eff = SIZE_BITS'(SLOT_BITS);
      end else begin
         size_eff = size_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < SLOT_BITS; k++) begin
         mask[k] = (SIZE_BITS'(k) < size_eff);
      end
   end

   assign left_w  = req_tdata[ID_FIELD_BITS-1:0];
   assign right_w = req_tdata[2*ID_FIELD_BITS-1:ID_FIELD_BITS];
   assign key_w   = {32'(left_w[KEY_ID_BITS-1:0]), 32'(right_w[KEY_ID_BITS-1:0])};
   assign pre_w   = key_w ^ (key_w >> MIX_SHIFT_A);

   // one 32x32 partial product per step; only the low 64 bits of each full product are kept
   assign mul_const = cmd.mul_pass ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a     = (cmd.mul_step == MUL_HL) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b     = (cmd.mul_step == MUL_LH) ? mul_const[63:32] : mul_const[31:0];
   assign mul_prod  = 64'(mul_a) * 64'(mul_b);
   assign sum_w     = acc_ff + {prod_ff[31:0], 32'd0};
   assign hash_w    = sum_w ^ (sum_w >> MIX_SHIFT_C);
   assign x_in      = cmd.load_req ? pre_w : (sum_w ^ (sum_w >> MIX_SHIFT_B));
   assign idx_in    = cmd.probe_advance ? ((idx_ff + SLOT_BITS'(1)) & mask)
                                        : (hash_w[SLOT_BITS-1:0] & mask);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         pair_ff <= {left_w[KEY_ID_BITS-1:0], right_w[KEY_ID_BITS-1:0]};
         rank_ff <= req_tdata[2*ID_FIELD_BITS+RANK_BITS-1:2*ID_FIELD_BITS];
         x_ff    <= x_in;
      end
      case (cmd.mul_step)
         MUL_LL: prod_ff <= mul_prod;
         MUL_LH: begin
            prod_ff <= mul_prod;
            acc_ff  <= prod_ff;
         end
         MUL_HL: begin
            prod_ff <= mul_prod;
            acc_ff  <= sum_w;
         end
         MUL_END: begin
            if (cmd.mul_pass) begin
               idx_ff   <= idx_in;
               probe_ff <= '0;
            end else begin
               x_ff <= x_in;
            end
         end
         default: ;
      endcase
      if (cmd.probe_advance) begin
         idx_ff   <= idx_in;
         probe_ff <= probe_ff + SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_addr_ff <= '0;
      end else if (cmd.wipe_write) begin
         wipe_addr_ff <= wipe_addr_ff + SLOT_BITS'(1);
      end
   end

   assign mem_we    = cmd.wipe_write || cmd.entry_write;
   assign mem_waddr = cmd.wipe_write ? wipe_addr_ff : idx_ff;
   assign mem_wdata = cmd.wipe_write ? '0 : {1'b1, pair_ff, rank_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_rank_ff   <= (cmd.rsp_status == STAT_HIT) ? rd_ff[RANK_BITS-1:0] : '0;
      end
   end

   assign stat.op         = op_ff;
   assign stat.rd_valid   = rd_ff[WORD_BITS-1];
   assign stat.rd_match   = (rd_ff[WORD_BITS-2:RANK_BITS] == pair_ff);
   assign stat.probe_last = (probe_ff == mask);
   assign stat.wipe_last  = &wipe_addr_ff;

   assign rsp_status = rsp_status_ff;
   assign rsp_rank   = rsp_rank_ff;

endmodule

`default_nettype wire

// File: rtl/pair_rank_hash_table.sv
// Top level of the pair rank hash table: linear probing on a splitmix64 hashed token pair.
//
//  port group  dir   fields (tdata / tuser, low bit first)
//  req_        in    tdata: left_id[15:0] right_id[31:16] rank_in[47:32]; tuser: op
//  rsp_        out   tdata: rank_out[15:0]; tuser: status
//  csr_        in    data: table_size_log2
//
//  Lookup/insert: the request is hashed, then the home slot is read and checked, and each extra
//  probe is another read and check; the next request is taken only once the result is registered.
//  The hash runs 8 steps on one shared 32x32 multiplier.
//  Clear: one slot per cycle over all 2**floor(log2(TABLE_SLOTS)) slots (131072 by default).
//  After reset the same wipe runs before the first request is taken; csr writes are taken.
//  One request in flight; a response waiting in the output register holds back its result, not its acceptance.
`default_nettype none

module pair_rank_hash_table #(
   parameter int TABLE_SLOTS = prht_pkg::DEF_TABLE_SLOTS,
   parameter int ID_BITS = prht_pkg::DEF_ID_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [47:0]                      req_tdata,  // left_id, right_id, rank_in
   input  wire logic [prht_pkg::OP_BITS-1:0]     req_tuser,  // op
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [prht_pkg::RANK_BITS-1:0]        rsp_tdata,  // rank_out
   output logic [prht_pkg::STATUS_BITS-1:0]      rsp_tuser,  // status
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [prht_pkg::SIZE_BITS-1:0]   csr_data
);
   import prht_pkg::*;

   prht_cmd_type  cmd;
   prht_stat_type stat;

   assign csr_ready = 1'b1;

   prht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   prht_dp #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .req_op     (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_tuser),
      .rsp_rank   (rsp_tdata)
   );

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("response loaded over an untaken response");

   a_write_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.entry_write |-> (cmd.rsp_load && cmd.rsp_status == STAT_INSERTED
                           && !cmd.wipe_write))
      else $error("slot written outside an insert result");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_LOOKUP || req_tuser == OP_INSERT))
      |=> !cmd.rsp_load)
      else $error("response loaded in the cycle after a request");

   a_rank_zero_unless_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_HIT) |-> (rsp_tdata == '0))
      else $error("nonzero rank on a non-hit response");

endmodule

`default_nettype wire

// File: test/tb_pair_rank_hash_table.sv
// Testbench for pair_rank_hash_table: directed table, then random requests checked by a predictor.
module tb_pair_rank_hash_table;
   timeunit 1ns;
   timeprecision 1ps;

   import prht_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 5;
   localparam int TABLE_LOG2 = $clog2(DEF_TABLE_SLOTS);
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam int POOL_SIZE = 32;
   localparam int PHASE_COUNT = 4;
   localparam int ITEMS_PER_PHASE = 202;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      prht_status_type         status;
      logic [RANK_BITS-1:0]    rank;
   } rank_reply_type;

   typedef struct {
      row_kind_type            kind;
      logic [OP_BITS-1:0]      op;
      logic [15:0]             left_id;
      logic [15:0]             right_id;
      logic [15:0]             rank_in;
      int                      count;
      bit                      typed;
      rank_reply_type          reply;
   } dir_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [47:0]                req_tdata = '0;    // left_id, right_id, rank_in
   logic [OP_BITS-1:0]         req_tuser = '0;    // op
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RANK_BITS-1:0]       rsp_tdata;         // rank_out
   logic [STATUS_BITS-1:0]     rsp_tuser;         // status
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [SIZE_BITS-1:0]       csr_data = '0;

   bit                         slot_used [DEF_TABLE_SLOTS];
   logic [31:0]                slot_key [DEF_TABLE_SLOTS];
   logic [RANK_BITS-1:0]       slot_rank [DEF_TABLE_SLOTS];
   logic [SIZE_BITS-1:0]       size_log2 = SIZE_RESET;

   rank_reply_type             rank_replies [$];
   dir_row_type                dir_rows [$];
   int                         mismatch_count = 0;
   int                         response_count = 0;
   int                         idle_cycles = 0;
   int                         send_gap_pct = 0;
   int                         recv_stall_pct = 0;
   logic [15:0]                pool_left [POOL_SIZE];
   logic [15:0]                pool_right [POOL_SIZE];

   pair_rank_hash_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic logic [31:0] pair_hash(logic [15:0] left_id, logic [15:0] right_id);
      logic [63:0] x;
      x = {16'd0, left_id, 16'd0, right_id};
      x = x ^ (x >> MIX_SHIFT_A);
      x = x * MIX_MUL_A;
      x = x ^ (x >> MIX_SHIFT_B);
      x = x * MIX_MUL_B;
      x = x ^ (x >> MIX_SHIFT_C);
      return x[31:0];
   endfunction

   function automatic rank_reply_type predict_rank(logic [OP_BITS-1:0] op, logic [15:0] left_id,
                                                   logic [15:0] right_id, logic [15:0] rank_in);
      rank_reply_type reply;
      int          lg;
      int unsigned n;
      int unsigned idx;
      int unsigned probes;
      logic [31:0] key;
      bit          done;
      reply.status = STAT_MISS;
      reply.rank = '0;
      if (op == OP_CLEAR) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         reply.status = STAT_CLEARED;
      end else if (op == OP_LOOKUP || op == OP_INSERT) begin
         lg = size_log2;
         if (lg < SIZE_MIN) lg = SIZE_MIN;
         if (lg > TABLE_LOG2) lg = TABLE_LOG2;
         n = 1 << lg;
         key = {left_id, right_id};
         idx = pair_hash(left_id, right_id) & (n - 1);
         reply.status = (op == OP_INSERT) ? STAT_FULL : STAT_MISS;
         probes = 0;
         done = 1'b0;
         while (probes < n && !done) begin
            if (!slot_used[idx]) begin
               if (op == OP_INSERT) begin
                  slot_used[idx] = 1'b1;
                  slot_key[idx] = key;
                  slot_rank[idx] = rank_in;
                  reply.status = STAT_INSERTED;
               end else begin
                  reply.status = STAT_MISS;
               end
               done = 1'b1;
            end else if (slot_key[idx] == key) begin
               if (op == OP_INSERT) begin
                  reply.status = STAT_DUP;
               end else begin
                  reply.status = STAT_HIT;
                  reply.rank = slot_rank[idx];
               end
               done = 1'b1;
            end else begin
               idx = (idx + 1) & (n - 1);
               probes++;
            end
         end
      end
      return reply;
   endfunction

   function automatic void add_row(row_kind_type kind, logic [OP_BITS-1:0] op,
                                   logic [15:0] left_id, logic [15:0] right_id,
                                   logic [15:0] rank_in, int count, bit typed,
                                   prht_status_type status, logic [15:0] rank_out);
      dir_row_type row;
      row.kind = kind;
      row.op = op;
      row.left_id = left_id;
      row.right_id = right_id;
      row.rank_in = rank_in;
      row.count = count;
      row.typed = typed;
      row.reply.status = status;
      row.reply.rank = rank_out;
      dir_rows.push_back(row);
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at response %0d: %s", response_count, msg);
      mismatch_count++;
   endtask

   task automatic send_request(logic [OP_BITS-1:0] op, logic [15:0] left_id,
                               logic [15:0] right_id, logic [15:0] rank_in,
                               bit typed, rank_reply_type typed_reply);
      rank_reply_type reply;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rank_in, right_id, left_id};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      reply = predict_rank(op, left_id, right_id, rank_in);
      if (typed)
         rank_replies.push_back(typed_reply);
      else
         rank_replies.push_back(reply);
   endtask

   task automatic write_size(logic [SIZE_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (rank_replies.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_log2 = value;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rank_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rank_replies.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending, status %0d rank %0d",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = rank_replies.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_tuser, want.status));
            if (rsp_tdata !== want.rank)
               report_mismatch($sformatf("rank got %0d expected %0d", rsp_tdata, want.rank));
         end
         response_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      dir_row_type     row;
      rank_reply_type  typed_reply;
      logic [OP_BITS-1:0] op;
      logic [15:0]     left_id;
      logic [15:0]     right_id;
      int              pick;
      int              counted;

      add_row(ROW_CFG, OP_LOOKUP, 16'h0000, 16'h0000, 16'd31, 1, 0, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1, 1, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 1, 1, STAT_INSERTED, 16'h0000);
      add_row(ROW_REQ, OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, STAT_INSERTED, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'h0000, 16'h0000, 16'h5A5A, 1, 1, STAT_HIT, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 1, STAT_HIT, 16'hFFFF);
      add_row(ROW_REQ, OP_INSERT, 16'hFFFF, 16'hFFFF, 16'h1234, 1, 1, STAT_DUP, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 1, STAT_HIT, 16'hFFFF);
      add_row(ROW_REQ, OP_INSERT, 16'hFFFF, 16'h0000, 16'h5555, 1, 1, STAT_INSERTED, 16'h0000);
      add_row(ROW_REQ, OP_INSERT, 16'h0000, 16'hFFFF, 16'hAAAA, 1, 1, STAT_INSERTED, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 1, 1, STAT_HIT, 16'h5555);
      add_row(ROW_REQ, OP_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000, 1, 1, STAT_HIT, 16'hAAAA);
      add_row(ROW_REQ, OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, STAT_MISS, 16'h0000);
      add_row(ROW_CFG, OP_LOOKUP, 16'h0000, 16'h0000, 16'd0, 1, 0, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1, 0, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_INSERT, 16'h0100, 16'h0200, 16'h7000, 20, 0, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_INSERT, 16'h0BAD, 16'h0BAD, 16'h0001, 1, 1, STAT_FULL, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'h0DEF, 16'h0DEF, 16'h0000, 1, 1, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'h0105, 16'h0205, 16'h0000, 1, 0, STAT_MISS, 16'h0000);
      add_row(ROW_CFG, OP_LOOKUP, 16'h0000, 16'h0000, 16'd17, 1, 0, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 1, STAT_HIT, 16'hFFFF);
      add_row(ROW_REQ, OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, STAT_CLEARED, 16'h0000);
      add_row(ROW_REQ, OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 1, STAT_MISS, 16'h0000);
      add_row(ROW_REQ, OP_INSERT, 16'h0001, 16'h0001, 16'h8000, 1, 1, STAT_INSERTED, 16'h0000);

      foreach (slot_used[i]) slot_used[i] = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CFG) begin
            write_size(row.rank_in[SIZE_BITS-1:0]);
         end else begin
            typed_reply = row.reply;
            for (int k = 0; k < row.count; k++)
               send_request(row.op, row.left_id + 16'(k), row.right_id + 16'(k),
                            row.rank_in + 16'(k), row.typed, typed_reply);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
               write_size(SIZE_BITS'($urandom_range(8, 5)));
            end
            1: begin
               send_gap_pct = 61;
               recv_stall_pct = 0;
               write_size(SIZE_MIN);
            end
            2: begin
               send_gap_pct = 0;
               recv_stall_pct = 61;
               write_size(SIZE_RESET);
               send_request(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 0,
                            typed_reply);
            end
            default: begin
               send_gap_pct = 13;
               recv_stall_pct = 13;
               write_size(SIZE_BITS'($urandom_range(31, 0)));
            end
         endcase
         foreach (pool_left[i]) begin
            pool_left[i] = 16'($urandom);
            pool_right[i] = 16'($urandom);
         end
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            op = (pick < 8) ? OP_UNUSED : (pick < 52) ? OP_LOOKUP : OP_INSERT;
            if ($urandom_range(3) != 0) begin
               pick = $urandom_range(POOL_SIZE - 1);
               left_id = pool_left[pick];
               right_id = pool_right[pick];
            end else begin
               left_id = 16'($urandom);
               right_id = 16'($urandom);
            end
            send_request(op, left_id, right_id, 16'($urandom), 0, typed_reply);
            counted++;
         end
      end

      req_tvalid <= 1'b0;
      while (rank_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/prht_pkg.sv
rtl/prht_ctrl.sv
rtl/prht_dp.sv
rtl/pair_rank_hash_table.sv
test/tb_pair_rank_hash_table.sv
